/* rtl/spnh_pkg.sv */
// Shared types, constants and helpers for the prefix/decimal-nonce SHA-1 core.
`timescale 1ns / 1ps
package spnh_pkg;

  localparam int unsigned DIGITS      = 10;   // a 32-bit value has at most 10 decimal digits
  localparam int unsigned ROUNDS      = 80;
  localparam int unsigned PREFIX_WDS  = 5;
  localparam int unsigned CFG_AW      = 5;    // byte address 0..31
  localparam int unsigned LEN_W       = 4;    // digit count 1..10

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] PAD_BYTE   = 8'h80;

  // reciprocal of 10: q = (v * RECIP10) >> 35 is exact for any 32-bit v
  localparam logic [31:0] RECIP10   = 32'hCCCCCCCD;
  localparam int unsigned RECIP_SH  = 35;

  // configuration register indexes
  localparam logic [2:0] REG_PREFIX0 = 3'd0;
  localparam logic [2:0] REG_PREFIX4 = 3'd4;

  // decimal conversion stage contents
  typedef struct packed {
    logic [31:0]              rem;    // value still to convert
    logic [DIGITS-1:0][3:0]   dig;    // least significant digit at index 0
    logic [31:0]              nonce;
  } spnh_dig_t;

  // compression stage contents: working variables and 16-word schedule window
  typedef struct packed {
    logic [31:0]         a;
    logic [31:0]         b;
    logic [31:0]         c;
    logic [31:0]         d;
    logic [31:0]         e;
    logic [15:0][31:0]   w;   // w[0] is the word used by the current round
    logic [31:0]         nonce;
  } spnh_rnd_t;

  function automatic logic [31:0] spnh_round_k(input int unsigned r);
    logic [31:0] k;
    if (r < 20) k = K0;
    else if (r < 40) k = K1;
    else if (r < 60) k = K2;
    else k = K3;
    return k;
  endfunction

endpackage

/* rtl/spnh_if.sv */
// Valid/ready channel interfaces for nonce words and digest words.
`timescale 1ns / 1ps
interface spnh_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] nonce;

  modport source (output valid, output nonce, input ready);
  modport sink   (input valid, input nonce, output ready);
endinterface

interface spnh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_w0;
  logic [31:0] digest_w1;
  logic [31:0] digest_w2;
  logic [31:0] digest_w3;
  logic [31:0] digest_w4;
  logic [31:0] nonce_tag;

  modport source (output valid, output digest_w0, output digest_w1, output digest_w2,
                  output digest_w3, output digest_w4, output nonce_tag, input ready);
  modport sink   (input valid, input digest_w0, input digest_w1, input digest_w2,
                  input digest_w3, input digest_w4, input nonce_tag, output ready);
endinterface

/* rtl/sha1_prefix_decimal_nonce_hash_core.sv */
// Top level: config registers, digit chain, message build, 80 round cells, output stage.
// Pipeline: an accepted nonce passes through 10 digit cells, 1 message build stage,
//   80 round cells and 1 output register before its digest words reach the output.
// Throughput: one nonce per cycle; the whole cell chain advances whenever the
//   output register is empty or being taken, so a stalled output holds the chain.
// Reset (rst_n, synchronous, active low) clears all stage valid bits and sets
//   the five prefix registers to zero.
`timescale 1ns / 1ps
module sha1_prefix_decimal_nonce_hash_core
  import spnh_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  spnh_in_if.sink            in_ch,
  spnh_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [PREFIX_WDS-1:0][31:0] prefix_r;
  logic [2:0]                  reg_idx;
  logic                        en;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= '0;
    end else if (psel && penable && pwrite && reg_idx <= REG_PREFIX4) begin
      prefix_r[reg_idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (reg_idx <= REG_PREFIX4) prdata = prefix_r[reg_idx];
  end

  // ---------------- chain enable ----------------
  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- decimal digit chain ----------------
  logic      [DIGITS:0] dig_v;
  spnh_dig_t [DIGITS:0] dig_d;

  // rem, dig, nonce
  assign dig_d[0] = {in_ch.nonce, {DIGITS{4'd0}}, in_ch.nonce};
  assign dig_v[0] = in_ch.valid;

  for (genvar g = 0; g < DIGITS; g++) begin : g_dig
    spnh_digit_cell #(.IDX(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dig_v[g]),
      .in_data   (dig_d[g]),
      .out_valid (dig_v[g+1]),
      .out_data  (dig_d[g+1])
    );
  end

  // ---------------- message build ----------------
  logic      [ROUNDS:0] rnd_v;
  spnh_rnd_t [ROUNDS:0] rnd_d;

  spnh_msg_build u_build (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dig_v[DIGITS]),
    .in_data   (dig_d[DIGITS]),
    .prefix    (prefix_r),
    .out_valid (rnd_v[0]),
    .out_data  (rnd_d[0])
  );

  // ---------------- round cells ----------------
  for (genvar r = 0; r < ROUNDS; r++) begin : g_rnd
    spnh_round_cell #(.ROUND(r)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (rnd_v[r]),
      .in_data   (rnd_d[r]),
      .out_valid (rnd_v[r+1]),
      .out_data  (rnd_d[r+1])
    );
  end

  // ---------------- output stage: add the initial values ----------------
  logic [31:0] h0_r, h1_r, h2_r, h3_r, h4_r, tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rnd_v[ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h0_r  <= IV0 + rnd_d[ROUNDS].a;
      h1_r  <= IV1 + rnd_d[ROUNDS].b;
      h2_r  <= IV2 + rnd_d[ROUNDS].c;
      h3_r  <= IV3 + rnd_d[ROUNDS].d;
      h4_r  <= IV4 + rnd_d[ROUNDS].e;
      tag_r <= rnd_d[ROUNDS].nonce;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.digest_w0 = h0_r;
  assign out_ch.digest_w1 = h1_r;
  assign out_ch.digest_w2 = h2_r;
  assign out_ch.digest_w3 = h3_r;
  assign out_ch.digest_w4 = h4_r;
  assign out_ch.nonce_tag = tag_r;

endmodule

/* rtl/spnh_digit_cell.sv */
// One decimal digit extraction cell: divides by ten and stores the remainder digit.
`timescale 1ns / 1ps
module spnh_digit_cell
  import spnh_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  spnh_dig_t in_data,
  output logic      out_valid,
  output spnh_dig_t out_data
);

  logic        valid_r;
  spnh_dig_t   data_r;
  spnh_dig_t   data_nxt;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [3:0]  q10;

  always_comb begin
    prod     = {32'd0, in_data.rem} * {32'd0, RECIP10};
    quot     = {3'd0, prod[63:RECIP_SH]};
    // only the low nibble of q*10 matters for the remainder digit
    q10      = {quot[0], 3'd0} + {quot[2:0], 1'b0};
    data_nxt = in_data;
    data_nxt.rem      = quot;
    data_nxt.dig[IDX] = in_data.rem[3:0] - q10;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* rtl/spnh_msg_build.sv */
// Message block assembly: prefix, decimal text, pad byte and length word.
`timescale 1ns / 1ps
module spnh_msg_build
  import spnh_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  spnh_dig_t                      in_data,
  input  logic [PREFIX_WDS-1:0][31:0]    prefix,
  output logic                           out_valid,
  output spnh_rnd_t                      out_data
);

  logic              valid_r;
  spnh_rnd_t         data_r;
  spnh_rnd_t         data_nxt;
  logic [LEN_W-1:0]  len;
  logic [39:0]       dig_flat;
  logic [47:0]       dig_top;
  logic [5:0]        shamt;
  logic [7:0]        byte_v;

  always_comb begin
    // digit count: position of the highest nonzero digit, at least one
    len = LEN_W'(1);
    for (int j = 1; j < DIGITS; j++) begin
      if (in_data.dig[j] != 4'd0) len = LEN_W'(j + 1);
    end

    dig_flat = in_data.dig;
    // left-justify so the most significant digit sits in the top nibble;
    // two spare nibbles below keep every byte slot's select in range
    shamt    = 6'({2'd0, LEN_W'(DIGITS)} - {2'd0, len}) << 2;
    dig_top  = {dig_flat, 8'd0} << shamt;

    data_nxt       = '0;
    data_nxt.a     = IV0;
    data_nxt.b     = IV1;
    data_nxt.c     = IV2;
    data_nxt.d     = IV3;
    data_nxt.e     = IV4;
    data_nxt.nonce = in_data.nonce;
    for (int i = 0; i < PREFIX_WDS; i++) begin
      data_nxt.w[i] = prefix[i];
    end
    // text bytes start at byte 20, i.e. word 5; 12 byte slots cover words 5..7
    for (int k = 0; k < 12; k++) begin
      if (k < DIGITS && LEN_W'(k) < len) begin
        byte_v = ASCII_ZERO | {4'd0, dig_top[4*(11-k) +: 4]};
      end else if (LEN_W'(k) == len) begin
        byte_v = PAD_BYTE;
      end else begin
        byte_v = 8'd0;
      end
      data_nxt.w[PREFIX_WDS + k/4][8*(3-(k%4)) +: 8] = byte_v;
    end
    data_nxt.w[15] = 32'd160 + {25'd0, len, 3'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* rtl/spnh_round_cell.sv */
// One SHA-1 round cell with its step of the message schedule.
`timescale 1ns / 1ps
module spnh_round_cell
  import spnh_pkg::*;
#(
  parameter int unsigned ROUND = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  spnh_rnd_t in_data,
  output logic      out_valid,
  output spnh_rnd_t out_data
);

  localparam int unsigned PHASE = ROUND / 20;
  localparam logic [31:0] KVAL  = spnh_round_k(ROUND);

  logic        valid_r;
  spnh_rnd_t   data_r;
  spnh_rnd_t   data_nxt;
  logic [31:0] f;
  logic [31:0] sx;

  always_comb begin
    case (PHASE)
      0:       f = (in_data.b & in_data.c) | (~in_data.b & in_data.d);
      2:       f = (in_data.b & in_data.c) | (in_data.b & in_data.d) |
                   (in_data.c & in_data.d);
      default: f = in_data.b ^ in_data.c ^ in_data.d;
    endcase

    // next schedule word W[i+16] from the window
    sx = in_data.w[13] ^ in_data.w[8] ^ in_data.w[2] ^ in_data.w[0];

    data_nxt       = in_data;
    data_nxt.a     = {in_data.a[26:0], in_data.a[31:27]} + f + in_data.e + KVAL + in_data.w[0];
    data_nxt.b     = in_data.a;
    data_nxt.c     = {in_data.b[1:0], in_data.b[31:2]};
    data_nxt.d     = in_data.c;
    data_nxt.e     = in_data.d;
    data_nxt.w     = {{sx[30:0], sx[31]}, in_data.w[15:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
